// ===== src/ip_address_text_parser_assert.svh =====
// ----------------------------------------------------------------------------
// ip_address_text_parser_assert.svh
// Assertion macros used by the address text parser top level.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define IP_ADDRESS_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define IPATP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define IPATP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ipatp_pkg.sv =====
// ----------------------------------------------------------------------------
// ipatp_pkg
// Types and constants for the IPv4 / IPv6 address text parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipatp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;

  // Limits
  localparam int unsigned MAX_OCTET     = 255;
  localparam int unsigned MAX_HEX_GROUP = 16'hffff;
  localparam int unsigned ADDR_BYTES    = 16;
  localparam int unsigned OCTETS        = 4;

  // Address family register values
  localparam logic FAMILY_IPV4 = 1'b0;
  localparam logic FAMILY_IPV6 = 1'b1;

  // Position relative to the start of the text
  localparam logic [1:0] AT_TEXT_START = 2'd0;
  localparam logic [1:0] AT_LEAD_COLON = 2'd1;
  localparam logic [1:0] AT_BODY       = 2'd2;

  // Eight 16-bit groups, group 0 in the low bits
  typedef logic [7:0][15:0] group_vec_t;

  // Running parse state
  typedef struct packed {
    group_vec_t  groups;
    logic [4:0]  bytes_written;
    logic [4:0]  gap_pos;
    logic        gap_seen;
    logic [15:0] hex_acc;
    logic        hex_seen;
    logic [7:0]  tok_dec;
    logic        tok_ok;
    logic        quad_mode;
    logic [2:0]  octet_cnt;
    logic        octet_seen;
    logic [31:0] quad_value;
    logic [1:0]  at_start;
    logic        failed;
    logic        text_ended;
  } parse_t;

  localparam parse_t PARSE_INIT = '{
    groups:        '0,
    bytes_written: 5'd0,
    gap_pos:       5'd0,
    gap_seen:      1'b0,
    hex_acc:       16'd0,
    hex_seen:      1'b0,
    tok_dec:       8'd0,
    tok_ok:        1'b1,
    quad_mode:     1'b0,
    octet_cnt:     3'd0,
    octet_seen:    1'b0,
    quad_value:    32'd0,
    at_start:      AT_TEXT_START,
    failed:        1'b0,
    text_ended:    1'b0
  };

endpackage

// ===== src/ipatp_step.sv =====
// ----------------------------------------------------------------------------
// ipatp_step
// Next parse state for one character of address text (combinational).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipatp_step (
  input  ipatp_pkg::parse_t state_i,
  input  logic [7:0]        char_i,
  input  logic              family_i,
  output ipatp_pkg::parse_t state_o
);

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= ipatp_pkg::CHAR_0) && (c <= ipatp_pkg::CHAR_9);
  endfunction

  // {hit, value} of a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (is_dec(c)) begin
      v = c - ipatp_pkg::CHAR_0;
      return {1'b1, v[3:0]};
    end else if ((c >= ipatp_pkg::CHAR_LO_A) && (c <= ipatp_pkg::CHAR_LO_F)) begin
      v = c - ipatp_pkg::CHAR_LO_A + 8'd10;
      return {1'b1, v[3:0]};
    end else if ((c >= ipatp_pkg::CHAR_UP_A) && (c <= ipatp_pkg::CHAR_UP_F)) begin
      v = c - ipatp_pkg::CHAR_UP_A + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  // token * 10 + digit, wide enough to see an overflow past one octet
  function automatic logic [11:0] dec_next(input logic [7:0] tok, input logic [7:0] c);
    logic [7:0] dig;
    dig = c - ipatp_pkg::CHAR_0;
    return ({4'd0, tok} << 3) + ({4'd0, tok} << 1) + {8'd0, dig[3:0]};
  endfunction

  // Dotted-quad rules, for IPv4 mode and the IPv6 tail
  function automatic ipatp_pkg::parse_t quad_char(input ipatp_pkg::parse_t s,
                                                  input logic [7:0] c);
    ipatp_pkg::parse_t r;
    logic [11:0]       nv;
    logic [2:0]        cnt;
    r   = s;
    nv  = dec_next(s.tok_dec, c);
    cnt = s.octet_cnt + 3'd1;
    if (is_dec(c)) begin
      if (nv > 12'(ipatp_pkg::MAX_OCTET)) begin
        r.failed = 1'b1;
      end else begin
        r.tok_dec = nv[7:0];
        if (!s.octet_seen) begin
          r.octet_cnt = cnt;
          if (cnt > 3'(ipatp_pkg::OCTETS)) begin
            r.failed = 1'b1;
          end else begin
            r.octet_seen = 1'b1;
          end
        end
      end
    end else if ((c == ipatp_pkg::CHAR_DOT) && s.octet_seen) begin
      if (s.octet_cnt == 3'(ipatp_pkg::OCTETS)) begin
        r.failed = 1'b1;
      end else begin
        r.quad_value = {s.quad_value[23:0], s.tok_dec};
        r.tok_dec    = 8'd0;
        r.octet_seen = 1'b0;
      end
    end else begin
      r.failed = 1'b1;
    end
    return r;
  endfunction

  // IPv6 rules: hex groups, one gap, dotted tail
  function automatic ipatp_pkg::parse_t v6_char(input ipatp_pkg::parse_t s,
                                                input logic [7:0] c);
    ipatp_pkg::parse_t r;
    logic [4:0]        hx;
    logic [19:0]       acc;
    logic [11:0]       nv;
    logic              go;
    r   = s;
    hx  = hex_of(c);
    acc = {s.hex_acc, hx[3:0]};
    nv  = dec_next(s.tok_dec, c);
    go  = 1'b1;
    if (s.quad_mode) begin
      return quad_char(s, c);
    end
    // Leading colon must be followed by a second one
    if (s.at_start == ipatp_pkg::AT_TEXT_START) begin
      r.at_start = ipatp_pkg::AT_BODY;
      if (c == ipatp_pkg::CHAR_COLON) begin
        r.at_start = ipatp_pkg::AT_LEAD_COLON;
        go         = 1'b0;
      end
    end else if (s.at_start == ipatp_pkg::AT_LEAD_COLON) begin
      if (c != ipatp_pkg::CHAR_COLON) begin
        r.failed = 1'b1;
        go       = 1'b0;
      end else begin
        r.at_start = ipatp_pkg::AT_BODY;
      end
    end
    if (go) begin
      if (hx[4]) begin
        if (acc > 20'(ipatp_pkg::MAX_HEX_GROUP)) begin
          r.failed = 1'b1;
        end else begin
          r.hex_acc  = acc[15:0];
          r.hex_seen = 1'b1;
          // decimal shadow of the token, for a possible dotted tail
          if (is_dec(c)) begin
            if (s.tok_ok) begin
              if (nv > 12'(ipatp_pkg::MAX_OCTET)) r.tok_ok = 1'b0;
              else r.tok_dec = nv[7:0];
            end
          end else begin
            r.tok_ok = 1'b0;
          end
        end
      end else if (c == ipatp_pkg::CHAR_COLON) begin
        r.tok_dec = 8'd0;
        r.tok_ok  = 1'b1;
        if (!s.hex_seen) begin
          if (s.gap_seen) begin
            r.failed = 1'b1;
          end else begin
            r.gap_seen = 1'b1;
            r.gap_pos  = s.bytes_written;
          end
        end else if ((6'(s.bytes_written) + 6'd2) > 6'(ipatp_pkg::ADDR_BYTES)) begin
          r.failed = 1'b1;
        end else begin
          r.groups[s.bytes_written[3:1]] = s.hex_acc;
          r.bytes_written = s.bytes_written + 5'd2;
          r.hex_seen      = 1'b0;
          r.hex_acc       = 16'd0;
        end
      end else if ((c == ipatp_pkg::CHAR_DOT) &&
                   ((6'(s.bytes_written) + 6'd4) <= 6'(ipatp_pkg::ADDR_BYTES)) &&
                   s.hex_seen && s.tok_ok) begin
        r.quad_mode  = 1'b1;
        r.octet_cnt  = 3'd1;
        r.quad_value = {24'd0, s.tok_dec};
        r.tok_dec    = 8'd0;
        r.octet_seen = 1'b0;
        r.hex_seen   = 1'b0;
      end else begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

  // Per-character update; ended or failed text ignores the rest
  always_comb begin
    state_o = state_i;
    if (!state_i.text_ended && !state_i.failed) begin
      if (char_i == ipatp_pkg::CHAR_NUL) begin
        if ((family_i == ipatp_pkg::FAMILY_IPV6) &&
            (state_i.at_start == ipatp_pkg::AT_LEAD_COLON)) begin
          state_o.failed = 1'b1;
        end
        state_o.text_ended = 1'b1;
      end else if (family_i == ipatp_pkg::FAMILY_IPV4) begin
        state_o = quad_char(state_i, char_i);
      end else begin
        state_o = v6_char(state_i, char_i);
      end
    end
  end

endmodule

// ===== src/ip_address_text_parser.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Streaming IPv4 / IPv6 address text parser.
//
// Input stream s_axis: one ASCII character per item in tdata, tlast on the
// final character of an address text. Every character updates the running
// parse in the cycle it is accepted; a new character can be taken each
// cycle while s_axis_tready is high (see Stall). Output stream m_axis: one
// item per text, tuser = well formed flag, tdata = address (zero when the
// text is bad). A text's result passes the gap expansion / result formatting
// stage, then the output register. Throughput is one character per cycle,
// including back-to-back texts, while m_axis does not stall.
// cfg_*: one-bit address family (0 IPv4, 1 IPv6), always ready; a write
// discards any text in progress. Write it only while the block is idle.
// Reset: family IPv6, parse state cleared, no result pending.
// Stall: while m_axis_tready is low the output register and the finish
// stage hold; characters are still taken until a last character fills the
// finish stage, then s_axis_tready drops for every character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ip_address_text_parser_assert.svh"

module ip_address_text_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,     // [0] address_family
  // character stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
  input  logic         s_axis_tlast,   // last
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] addr_high, [127:64] addr_low
  output logic         m_axis_tuser    // [0] valid_res
);

  // Handshakes
  logic s_acc;
  logic cfg_acc;
  logic out_free;
  logic fin_adv;

  // Configuration and parse state
  logic              family_q;
  ipatp_pkg::parse_t parse_q, parse_d, step_nx;

  // Finish stage: snapshot of the state after the last character
  logic              fin_valid_q;
  ipatp_pkg::parse_t fin_q;
  logic              fin_family_q;

  // Finish logic
  ipatp_pkg::group_vec_t fin_grp, rot_grp, moved_grp;
  logic [4:0]            fin_bw;
  logic [2:0]            store_idx;
  logic [31:0]           quad_word;
  logic [2:0]            gap_idx;
  logic [3:0]            words;
  logic [3:0]            tail_n;
  logic [2:0]            rot_amt;
  logic [255:0]          rot_wide;
  logic                  v6_bad;
  logic                  res_ok;
  logic [63:0]           res_hi, res_lo;

  // Output register
  logic        out_valid_q;
  logic        out_ok_q;
  logic [63:0] out_hi_q, out_lo_q;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fin_adv       = fin_valid_q && out_free;
  assign s_axis_tready = !fin_valid_q || out_free;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  // Character step
  ipatp_step u_step (
    .state_i  (parse_q),
    .char_i   (s_axis_tdata),
    .family_i (family_q),
    .state_o  (step_nx)
  );

  // Next parse state: a config write or the end of a text starts fresh
  always_comb begin
    parse_d = parse_q;
    if (cfg_acc) begin
      parse_d = ipatp_pkg::PARSE_INIT;
    end else if (s_acc) begin
      parse_d = s_axis_tlast ? ipatp_pkg::PARSE_INIT : step_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= ipatp_pkg::FAMILY_IPV6;
      parse_q  <= ipatp_pkg::PARSE_INIT;
    end else begin
      if (cfg_acc) family_q <= cfg_data_i;
      parse_q <= parse_d;
    end
  end

  // Finish stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (s_acc && s_axis_tlast) begin
      fin_valid_q <= 1'b1;
    end else if (fin_adv) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tlast) begin
      fin_q        <= step_nx;
      fin_family_q <= family_q;
    end
  end

  // Close the text: store the pending group or dotted tail, expand the gap
  always_comb begin
    fin_grp   = fin_q.groups;
    fin_bw    = fin_q.bytes_written;
    store_idx = fin_bw[3:1];
    quad_word = {fin_q.quad_value[23:0], fin_q.tok_dec};
    v6_bad    = fin_q.failed || (fin_q.at_start == ipatp_pkg::AT_LEAD_COLON);
    if (fin_q.quad_mode) begin
      if (fin_q.octet_cnt < 3'(ipatp_pkg::OCTETS)) v6_bad = 1'b1;
      fin_grp[store_idx]        = quad_word[31:16];
      fin_grp[store_idx + 3'd1] = quad_word[15:0];
      fin_bw                    = fin_bw + 5'd4;
    end else if (fin_q.hex_seen) begin
      if ((6'(fin_bw) + 6'd2) > 6'(ipatp_pkg::ADDR_BYTES)) begin
        v6_bad = 1'b1;
      end else begin
        fin_grp[store_idx] = fin_q.hex_acc;
        fin_bw             = fin_bw + 5'd2;
      end
    end

    // Groups written after the gap move to the top: a rotate plus masks
    gap_idx = fin_q.gap_pos[3:1];
    words   = fin_bw[4:1];
    tail_n  = (words > {1'b0, gap_idx}) ? (words - {1'b0, gap_idx}) : 4'd0;
    if (tail_n > 4'd8) tail_n = 4'd8;
    rot_amt  = gap_idx + tail_n[2:0];
    rot_wide = {fin_grp, fin_grp} >> {rot_amt, 4'b0000};
    rot_grp  = rot_wide[127:0];
    for (int j = 0; j < 8; j++) begin
      if ((tail_n == 4'd8) || ((4'(j) + tail_n) >= 4'd8)) begin
        moved_grp[3'(j)] = rot_grp[3'(j)];
      end else if (3'(j) < gap_idx) begin
        moved_grp[3'(j)] = fin_grp[3'(j)];
      end else begin
        moved_grp[3'(j)] = 16'd0;
      end
    end
    if (fin_q.gap_seen) begin
      fin_grp = moved_grp;
      fin_bw  = 5'(ipatp_pkg::ADDR_BYTES);
    end

    // Result per family; zero address when the text is bad
    res_ok = 1'b0;
    res_hi = 64'd0;
    res_lo = 64'd0;
    if (fin_family_q == ipatp_pkg::FAMILY_IPV4) begin
      if (!fin_q.failed && (fin_q.octet_cnt >= 3'(ipatp_pkg::OCTETS))) begin
        res_ok = 1'b1;
        res_lo = {32'd0, quad_word};
      end
    end else if (!v6_bad && (fin_bw == 5'(ipatp_pkg::ADDR_BYTES))) begin
      res_ok = 1'b1;
      res_hi = {fin_grp[0], fin_grp[1], fin_grp[2], fin_grp[3]};
      res_lo = {fin_grp[4], fin_grp[5], fin_grp[6], fin_grp[7]};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_adv) begin
      out_ok_q <= res_ok;
      out_hi_q <= res_hi;
      out_lo_q <= res_lo;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_lo_q, out_hi_q};
  assign m_axis_tuser  = out_ok_q;

  // Checks
  `IPATP_ASSERT_NEXT(a_last_loads_finish, s_acc && s_axis_tlast, fin_valid_q,
    "last character did not load the finish stage")
  `IPATP_ASSERT_NEXT(a_finish_reaches_output, fin_adv, out_valid_q,
    "finish stage advanced without an output item")
  `IPATP_ASSERT_NOW(a_bad_text_zero_addr, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata == 128'd0, "bad text produced a nonzero address")
  `IPATP_ASSERT_NOW(a_bytes_sane, 1'b1,
    (parse_q.bytes_written <= 5'(ipatp_pkg::ADDR_BYTES)) && !parse_q.bytes_written[0] &&
    (parse_q.gap_pos <= parse_q.bytes_written),
    "group byte count or gap position out of range")

endmodule
